[hw/rtl/sce_pkg.sv]
// ----------------------------------------------------------------------------
// sce_pkg
// Shared constants and types for the stepper command frame encoder.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0] HDR_A       = 8'hAA;
    localparam logic [7:0] HDR_B       = 8'h55;
    localparam logic [7:0] CODE_REL    = 8'h11;
    localparam logic [7:0] CODE_ORIGIN = 8'h12;
    localparam logic [7:0] CODE_ABS    = 8'h13;
    localparam logic [7:0] CODE_CURR   = 8'h14;
    localparam logic [7:0] CODE_MODE   = 8'h15;
    localparam logic [7:0] CODE_UDIR   = 8'h16;
    localparam logic [7:0] CODE_REBOOT = 8'h17;
    localparam logic [7:0] CODE_POWER  = 8'h19;

    localparam logic [3:0] OP_WAKE   = 4'd0;
    localparam logic [3:0] OP_SLEEP  = 4'd1;
    localparam logic [3:0] OP_ORIGIN = 4'd2;
    localparam logic [3:0] OP_REL    = 4'd3;
    localparam logic [3:0] OP_ABS    = 4'd4;
    localparam logic [3:0] OP_CURR   = 4'd5;
    localparam logic [3:0] OP_MODE   = 4'd6;
    localparam logic [3:0] OP_UDIR   = 4'd7;
    localparam logic [3:0] OP_REBOOT = 4'd8;

    localparam logic CFG_DEV_ADDR    = 1'b0;
    localparam logic CFG_MAX_DEGREES = 1'b1;

    localparam logic [7:0] DEV_ADDR_RST    = 8'd1;
    localparam logic [9:0] MAX_DEGREES_RST = 10'd45;

    // pulses = (mag*16384 + 180) / 360 = (mag*4096 + 45) / 90
    // exact reciprocal for 22-bit numerators: ceil(2^29 / 90)
    localparam int          RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_90    = 23'd5965233;
    localparam logic [21:0] ROUND_45    = 22'd45;

    typedef struct packed {
        logic                          emit;
        logic [IDX_W-1:0]              cnt;   // bytes before the checksum
        logic [FRAME_BYTES-1:0][7:0]   bytes;
    } t_frame;

endpackage

[hw/rtl/sce_frame_build.sv]
// ----------------------------------------------------------------------------
// sce_frame_build
// Builds the frame bytes of one command: header, id, code, length, data.
// ----------------------------------------------------------------------------
module sce_frame_build (
    input  logic [3:0]           i_op,
    input  logic signed [15:0]   i_degrees,
    input  logic [7:0]           i_arg,
    input  logic [7:0]           i_dev_addr,
    input  logic [9:0]           i_max_degrees,
    output sce_pkg::t_frame      o_frame
);
    import sce_pkg::*;

    logic signed [16:0] w_deg;
    logic signed [16:0] w_lim;
    logic signed [16:0] w_clamp;
    logic signed [16:0] w_abs;
    logic [9:0]         w_mag;
    logic [21:0]        w_num;
    logic [44:0]        w_prod;
    logic [15:0]        w_pulses;
    logic               w_pos;
    logic               w_nonneg;

    assign w_deg  = 17'(i_degrees);
    assign w_lim  = $signed({7'd0, i_max_degrees});

    always_comb begin
        if (w_deg > w_lim) begin
            w_clamp = w_lim;
        end else if (w_deg < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_deg;
        end
    end

    assign w_abs    = w_clamp[16] ? -w_clamp : w_clamp;
    assign w_mag    = w_abs[9:0];
    assign w_num    = {w_mag, 12'd0} + ROUND_45;
    assign w_prod   = 45'(w_num) * 45'(RECIP_90);
    // clamped magnitude is at most 1023, so the quotient stays below 65535
    assign w_pulses = w_prod[RECIP_SHIFT +: 16];
    assign w_pos    = !w_clamp[16] && (w_clamp != 17'sd0);
    assign w_nonneg = !w_clamp[16];

    always_comb begin
        o_frame          = '0;
        o_frame.emit     = 1'b1;
        o_frame.bytes[0] = HDR_A;
        o_frame.bytes[1] = HDR_B;
        o_frame.bytes[2] = i_dev_addr;
        case (i_op)
            OP_WAKE: begin
                o_frame.bytes[3] = CODE_POWER;
                o_frame.bytes[4] = 8'd1;
                o_frame.bytes[5] = 8'd1;
                o_frame.cnt      = IDX_W'(6);
            end
            OP_SLEEP: begin
                o_frame.bytes[3] = CODE_POWER;
                o_frame.bytes[4] = 8'd1;
                o_frame.bytes[5] = 8'd0;
                o_frame.cnt      = IDX_W'(6);
            end
            OP_ORIGIN: begin
                o_frame.bytes[3] = CODE_ORIGIN;
                o_frame.bytes[4] = 8'd0;
                o_frame.cnt      = IDX_W'(5);
            end
            OP_REL: begin
                o_frame.emit     = (i_degrees != 16'sd0);
                o_frame.bytes[3] = CODE_REL;
                o_frame.bytes[4] = 8'd5;
                o_frame.bytes[5] = {7'd0, w_pos};
                o_frame.bytes[6] = 8'd0;
                o_frame.bytes[7] = 8'd0;
                o_frame.bytes[8] = w_pulses[7:0];
                o_frame.bytes[9] = w_pulses[15:8];
                o_frame.cnt      = IDX_W'(10);
            end
            OP_ABS: begin
                o_frame.bytes[3] = CODE_ABS;
                o_frame.bytes[4] = 8'd3;
                o_frame.bytes[5] = {7'd0, w_nonneg};
                o_frame.bytes[6] = w_pulses[7:0];
                o_frame.bytes[7] = w_pulses[15:8];
                o_frame.cnt      = IDX_W'(8);
            end
            OP_CURR: begin
                o_frame.bytes[3] = CODE_CURR;
                o_frame.bytes[4] = 8'd1;
                o_frame.bytes[5] = i_arg;
                o_frame.cnt      = IDX_W'(6);
            end
            OP_MODE: begin
                o_frame.bytes[3] = CODE_MODE;
                o_frame.bytes[4] = 8'd1;
                o_frame.bytes[5] = i_arg;
                o_frame.cnt      = IDX_W'(6);
            end
            OP_UDIR: begin
                o_frame.bytes[3] = CODE_UDIR;
                o_frame.bytes[4] = 8'd1;
                o_frame.bytes[5] = i_arg;
                o_frame.cnt      = IDX_W'(6);
            end
            OP_REBOOT: begin
                o_frame.bytes[3] = CODE_REBOOT;
                o_frame.bytes[4] = 8'd0;
                o_frame.cnt      = IDX_W'(5);
            end
            default: begin
                o_frame.emit = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/sce_serializer.sv]
// ----------------------------------------------------------------------------
// sce_serializer
// Holds one frame and sends it a byte per transaction, closing with the
// running checksum.
// ----------------------------------------------------------------------------
module sce_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_frame_vld,
    input  sce_pkg::t_frame  i_frame,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_tx_byte,
    output logic             o_last
);
    import sce_pkg::*;

    logic [7:0]       r_bytes [FRAME_BYTES];
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic [7:0]       r_sum;
    logic             r_ovld;
    logic [7:0]       r_obyte;
    logic             r_olast;

    logic             w_adv;
    logic             w_at_sum;
    logic             w_load;
    logic [7:0]       w_byte;

    assign w_adv    = r_busy && (!r_ovld || !i_stall);
    assign w_at_sum = (r_idx == r_cnt);
    assign o_take   = i_frame_vld && (!i_frame.emit || !r_busy || (w_adv && w_at_sum));
    assign w_load   = o_take && i_frame.emit;
    assign w_byte   = w_at_sum ? r_sum : r_bytes[r_idx[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_adv) begin
                if (w_at_sum) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (w_adv) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_bytes[i] <= i_frame.bytes[i];
            end
            r_cnt <= i_frame.cnt;
            r_sum <= '0;
        end else if (w_adv && !w_at_sum && (r_idx >= IDX_W'(2))) begin
            r_sum <= r_sum + w_byte;
        end
        if (w_adv) begin
            r_obyte <= w_byte;
            r_olast <= w_at_sum;
        end
    end

    assign o_valid   = r_ovld;
    assign o_tx_byte = r_obyte;
    assign o_last    = r_olast;

endmodule

[hw/rtl/stepper_command_frame_encoder_top.sv]
// ----------------------------------------------------------------------------
// stepper_command_frame_encoder_top
// Encodes motor commands into serial frames, one byte per output transaction.
// ----------------------------------------------------------------------------
// The command is registered at the input, loaded into the serializer's frame
// register, and each byte then leaves through the single byte-wide output
// register, one byte per cycle while i_stall is low; a frame is 6 to 11 bytes.
// Commands that produce no frame are absorbed without waiting for the serializer.
// Reset: synchronous active low; clears all valids, address = 1,
// max_degrees = 45.
module stepper_command_frame_encoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_op,
    input  logic signed [15:0] i_degrees,
    input  logic [7:0]         i_arg,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_tx_byte,
    output logic               o_last
);
    import sce_pkg::*;

    logic [7:0]         r_dev_addr;
    logic [9:0]         r_max_degrees;
    logic               r_in_vld;
    logic [3:0]         r_op;
    logic signed [15:0] r_degrees;
    logic [7:0]         r_arg;

    t_frame             w_frame;
    logic               w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= DEV_ADDR_RST;
            r_max_degrees <= MAX_DEGREES_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[7:0];
                CFG_MAX_DEGREES: r_max_degrees <= i_cfg_data;
                default:         r_dev_addr    <= r_dev_addr;
            endcase
        end
    end

    assign o_stall = r_in_vld && !w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op      <= i_op;
            r_degrees <= i_degrees;
            r_arg     <= i_arg;
        end
    end

    sce_frame_build u_build (
        .i_op          (r_op),
        .i_degrees     (r_degrees),
        .i_arg         (r_arg),
        .i_dev_addr    (r_dev_addr),
        .i_max_degrees (r_max_degrees),
        .o_frame       (w_frame)
    );

    sce_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_vld (r_in_vld),
        .i_frame     (w_frame),
        .o_take      (w_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule

[hw/rtl/sce_checker.sv]
// ----------------------------------------------------------------------------
// sce_checker
// Port-level checks on the frame output of the encoder.
// ----------------------------------------------------------------------------
module sce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_tx_byte,
    input logic       o_last
);
    import sce_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx_byte) && $stable(o_last))
        else $error("stalled output transaction changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall right after reset");

    a_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("gap inside a frame");

    a_next_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid || (o_tx_byte == HDR_A))
        else $error("frame does not start with header");

endmodule

bind stepper_command_frame_encoder_top sce_checker u_sce_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_tx_byte (o_tx_byte),
    .o_last    (o_last)
);

[tb/stepper_command_frame_encoder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_command_frame_encoder_top_test
// Drives motor commands into the frame encoder with random idle bursts and
// backpressure. A scoreboard builds each expected frame from the command and
// the current device id and angle limit, then checks every output byte and
// its last flag in order.
// ----------------------------------------------------------------------------
module stepper_command_frame_encoder_top_test;
    import sce_pkg::*;

    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int         CYCLE_LIMIT  = 100000;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_frame_byte;

    class frame_scoreboard;
        logic [7:0]  dev_addr;
        logic [9:0]  max_degrees;
        t_frame_byte frame_bytes[$];
        int          failures;
        int          frames_noted;

        function new();
            dev_addr     = DEV_ADDR_RST;
            max_degrees  = MAX_DEGREES_RST;
            failures     = 0;
            frames_noted = 0;
        endfunction

        function void set_register(logic index, logic [9:0] value);
            if (index == CFG_DEV_ADDR) begin
                dev_addr = value[7:0];
            end else begin
                max_degrees = value;
            end
        endfunction

        function void note_command(logic [3:0] op, logic signed [15:0] degrees,
                                   logic [7:0] arg);
            logic [7:0]  code;
            logic [7:0]  payload[$];
            logic [7:0]  sum;
            int          angle;
            int          lim;
            int unsigned mag;
            int unsigned pulses;
            t_frame_byte fb;
            angle = int'(degrees);
            lim   = int'(max_degrees);
            if (angle > lim) angle = lim;
            if (angle < -lim) angle = -lim;
            mag    = (angle < 0) ? -angle : angle;
            pulses = (mag * 16384 + 180) / 360;
            if (pulses > 65535) pulses = 65535;
            case (op)
                OP_WAKE: begin
                    code = CODE_POWER;
                    payload.push_back(8'd1);
                end
                OP_SLEEP: begin
                    code = CODE_POWER;
                    payload.push_back(8'd0);
                end
                OP_ORIGIN: code = CODE_ORIGIN;
                OP_REL: begin
                    // zero relative move is dropped before clamping
                    if (degrees == 0) return;
                    code = CODE_REL;
                    payload.push_back((angle > 0) ? 8'd1 : 8'd0);
                    payload.push_back(8'd0);
                    payload.push_back(8'd0);
                    payload.push_back(pulses[7:0]);
                    payload.push_back(pulses[15:8]);
                end
                OP_ABS: begin
                    code = CODE_ABS;
                    payload.push_back((angle >= 0) ? 8'd1 : 8'd0);
                    payload.push_back(pulses[7:0]);
                    payload.push_back(pulses[15:8]);
                end
                OP_CURR: begin
                    code = CODE_CURR;
                    payload.push_back(arg);
                end
                OP_MODE: begin
                    code = CODE_MODE;
                    payload.push_back(arg);
                end
                OP_UDIR: begin
                    code = CODE_UDIR;
                    payload.push_back(arg);
                end
                OP_REBOOT: code = CODE_REBOOT;
                default: return;
            endcase
            frames_noted++;
            fb.last = 1'b0;
            fb.tx_byte = HDR_A;
            frame_bytes.push_back(fb);
            fb.tx_byte = HDR_B;
            frame_bytes.push_back(fb);
            fb.tx_byte = dev_addr;
            frame_bytes.push_back(fb);
            fb.tx_byte = code;
            frame_bytes.push_back(fb);
            fb.tx_byte = 8'(payload.size());
            frame_bytes.push_back(fb);
            sum = dev_addr + code + 8'(payload.size());
            foreach (payload[i]) begin
                fb.tx_byte = payload[i];
                frame_bytes.push_back(fb);
                sum += payload[i];
            end
            fb.tx_byte = sum;
            fb.last    = 1'b1;
            frame_bytes.push_back(fb);
        endfunction

        function void check_byte(logic [7:0] tx_byte, logic last);
            t_frame_byte exp_byte;
            if (frame_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                         $time, tx_byte, last);
                failures++;
                return;
            end
            exp_byte = frame_bytes.pop_front();
            if (tx_byte !== exp_byte.tx_byte) begin
                $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                         $time, exp_byte.tx_byte, tx_byte);
                failures++;
            end
            if (last !== exp_byte.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, exp_byte.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return frame_bytes.size();
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic               i_cfg_index = CFG_DEV_ADDR;
    logic [9:0]         i_cfg_data  = '0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [3:0]         i_op        = OP_WAKE;
    logic signed [15:0] i_degrees   = '0;
    logic [7:0]         i_arg       = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [7:0]         o_tx_byte;
    logic               o_last;

    frame_scoreboard sb = new();
    bit              idle_on       = 1'b1;
    int              hold_request  = 0;
    int              hold_left     = 0;
    int              burst_left    = 0;
    int              cycle_count   = 0;

    stepper_command_frame_encoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_degrees   (i_degrees),
        .i_arg       (i_arg),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stepper_command_frame_encoder_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_byte(o_tx_byte, o_last);
        end
    end

    // output backpressure: long hold on request, else short random bursts
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall = 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 2);
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send_command(logic [3:0] op, logic signed [15:0] degrees,
                                logic [7:0] arg);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_op      = op;
        i_degrees = degrees;
        i_arg     = arg;
        i_valid   = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(op, degrees, arg);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic index, logic [9:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        sb.set_register(index, value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    function automatic logic signed [15:0] random_degrees(int lim);
        int d;
        case ($urandom_range(0, 5))
            0: d = 0;
            1: d = int'($urandom_range(0, 2 * lim + 2)) - (lim + 1);
            2: d = int'($urandom_range(0, 65535)) - 32768;
            3: d = $urandom_range(0, 1) ? lim : -lim;
            4: d = $urandom_range(0, 1) ? lim + 1 : -(lim + 1);
            default: d = $urandom_range(0, 1) ? int'($urandom_range(1, 3))
                                               : -int'($urandom_range(1, 3));
        endcase
        return d[15:0];
    endfunction

    task automatic run_random_commands(int frames);
        int         target;
        logic [3:0] op;
        target = sb.frames_noted + frames;
        while (sb.frames_noted < target) begin
            if ($urandom_range(0, 9) == 0) begin
                op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else begin
                op = 4'($urandom_range(OP_WAKE, OP_REBOOT));
            end
            send_command(op, random_degrees(int'(sb.max_degrees)),
                         8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_config();
        logic [9:0] limit;
        case ($urandom_range(0, 3))
            0: limit = 10'd0;
            1: limit = 10'd1023;
            default: limit = 10'($urandom_range(0, 1023));
        endcase
        write_register(CFG_DEV_ADDR, 10'($urandom_range(0, 1023)));
        write_register(CFG_MAX_DEGREES, limit);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: every op, direction edges, ignored codes
        send_command(OP_WAKE, 16'sd0, 8'h00);
        send_command(OP_SLEEP, 16'sd0, 8'hFF);
        send_command(OP_ORIGIN, 16'sd0, 8'h00);
        send_command(OP_REL, 16'sd0, 8'h00);
        send_command(OP_REL, 16'sd30, 8'h00);
        send_command(OP_REL, -16'sd32768, 8'h00);
        send_command(OP_REL, 16'sd32767, 8'h00);
        send_command(OP_ABS, 16'sd0, 8'h00);
        send_command(OP_ABS, -16'sd1, 8'h00);
        send_command(OP_ABS, 16'sd45, 8'h00);
        send_command(OP_CURR, 16'sd0, 8'h00);
        send_command(OP_CURR, 16'sd0, 8'hFF);
        send_command(OP_MODE, 16'sd0, 8'hA5);
        send_command(OP_UDIR, 16'sd0, 8'h5A);
        send_command(OP_REBOOT, 16'sd0, 8'h00);
        send_command(OP_UNUSED_LO, 16'sd100, 8'h11);
        send_command(OP_UNUSED_HI, -16'sd1, 8'hFF);
        wait_idle();

        write_register(CFG_DEV_ADDR, 10'h3FF);
        write_register(CFG_MAX_DEGREES, 10'd1023);
        send_command(OP_REL, 16'sd1023, 8'h00);
        send_command(OP_ABS, -16'sd32768, 8'h00);
        wait_idle();

        // zero limit: nonzero moves collapse to a zero-pulse frame
        write_register(CFG_DEV_ADDR, 10'd0);
        write_register(CFG_MAX_DEGREES, 10'd0);
        send_command(OP_REL, 16'sd5, 8'h00);
        send_command(OP_ABS, -16'sd7, 8'h00);
        wait_idle();

        random_config();
        run_random_commands(40);
        wait_idle();

        // long output hold with no input gaps to back up the pipeline
        idle_on = 1'b0;
        write_register(CFG_DEV_ADDR, 10'($urandom_range(0, 255)));
        write_register(CFG_MAX_DEGREES, 10'd1023);
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        @(negedge i_clk);
        run_random_commands(40);
        wait_idle();
        idle_on = 1'b1;

        write_register(CFG_DEV_ADDR, 10'd0);
        write_register(CFG_MAX_DEGREES, 10'd0);
        run_random_commands(40);
        wait_idle();

        random_config();
        run_random_commands(20);
        wait_idle();
        run_random_commands(20);
        wait_idle();

        random_config();
        run_random_commands(20);
        wait_idle();

        idle_on = 1'b0;
        random_config();
        run_random_commands(20);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("stepper_command_frame_encoder_top test passed");
        end else begin
            $display("stepper_command_frame_encoder_top test failed");
        end
        $finish;
    end

endmodule

[stepper_command_frame_encoder_top.f]
hw/rtl/sce_pkg.sv
hw/rtl/sce_frame_build.sv
hw/rtl/sce_serializer.sv
hw/rtl/stepper_command_frame_encoder_top.sv
hw/rtl/sce_checker.sv
tb/stepper_command_frame_encoder_top_test.sv
